@@ src/stun_pkg.sv @@
package stun_pkg;

	localparam logic [31:0] StunCookie    = 32'h2112A442;
	localparam logic [16:0] HdrBytes      = 17'd20;
	localparam logic [16:0] CountMax      = 17'h1FFFF;
	localparam logic [7:0]  FamilyV4      = 8'h01;

	localparam logic [15:0] AttrMapped     = 16'h0001;
	localparam logic [15:0] AttrXorMapped  = 16'h0020;
	localparam logic [15:0] AttrXorRelayed = 16'h0016;
	localparam logic [15:0] AttrLifetime   = 16'h000D;
	localparam logic [15:0] AttrError      = 16'h0009;

	localparam logic [1:0] CfgCheckTid = 2'd0;
	localparam logic [1:0] CfgTidHigh  = 2'd1;
	localparam logic [1:0] CfgTidLow   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic        parse_ok;
		logic [15:0] message_type;
		logic        mapped_valid;
		logic [31:0] mapped_ip;
		logic [15:0] mapped_port;
		logic        relayed_valid;
		logic [31:0] relayed_ip;
		logic [15:0] relayed_port;
		logic [31:0] lifetime_seconds;
		logic        error_valid;
		logic [15:0] error_code;
	} out_t;

	typedef struct packed {
		logic        mapped_valid;
		logic [31:0] mapped_ip;
		logic [15:0] mapped_port;
		logic        relayed_valid;
		logic [31:0] relayed_ip;
		logic [15:0] relayed_port;
		logic [31:0] lifetime_seconds;
		logic        error_valid;
		logic [15:0] error_code;
	} found_t;

endpackage

@@ src/stun_response_parser.sv @@
// path from an accepted byte to its summary: input register, then result register
// throughput: one byte per cycle; a byte's whole update is one pass of logic on the input register
// a summary waits in the result register while the next datagram's bytes keep flowing in;
// only a final byte that finds the result register full and stalled holds the input
// reset: parser state, configuration and both valid flags clear at once; no warm-up pass
module stun_response_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stun_pkg::in_t      in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stun_pkg::out_t     out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	logic        check_tid_q;
	logic [31:0] tid_high_q;
	logic [63:0] tid_low_q;

	logic           valid_s1;
	stun_pkg::in_t  data_s1;
	logic           adv;

	logic [16:0]      byte_count_q, n_count;
	logic [15:0]      header_type_q, n_type;
	logic [15:0]      body_length_q, n_len;
	logic             header_fail_q, n_fail;
	logic             walk_stopped_q, n_stopped;
	logic [15:0]      attr_kind_q, n_kind;
	logic [15:0]      attr_size_q, n_size;
	logic [16:0]      attr_offset_q, n_offset;
	logic [63:0]      value_window_q, n_window;
	stun_pkg::found_t found_q, n_found;

	logic             out_valid_q;
	stun_pkg::out_t   out_data_q;
	stun_pkg::out_t   res;

	logic [7:0]  b;
	logic [16:0] off, k, v, padded;
	logic [95:0] tid_all;
	logic [7:0]  cookie_b, tid_b;
	logic [3:0]  tid_i;
	logic [15:0] port_x;
	logic [31:0] ip_x;
	logic        stop_now, ok;

	assign adv      = valid_s1 && (!data_s1.last_byte || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign b        = data_s1.data_byte;
	assign tid_all  = {tid_high_q, tid_low_q};

	always_comb begin
		n_count   = byte_count_q;
		n_type    = header_type_q;
		n_len     = body_length_q;
		n_fail    = header_fail_q;
		n_stopped = walk_stopped_q;
		n_kind    = attr_kind_q;
		n_size    = attr_size_q;
		n_offset  = attr_offset_q;
		n_window  = value_window_q;
		n_found   = found_q;
		stop_now  = 1'b0;
		port_x    = '0;
		ip_x      = '0;
		off       = byte_count_q - stun_pkg::HdrBytes;
		k         = off - attr_offset_q;
		v         = k - 17'd4;
		padded    = '0;
		cookie_b  = stun_pkg::StunCookie[8 * (3 - byte_count_q[1:0]) +: 8];
		tid_i     = 4'(byte_count_q - 17'd8);
		tid_b     = tid_all[8 * (11 - 32'(tid_i)) +: 8];

		if (byte_count_q < stun_pkg::HdrBytes) begin
			if (byte_count_q < 17'd2) begin
				n_type = {header_type_q[7:0], b};
			end else if (byte_count_q < 17'd4) begin
				n_len = {body_length_q[7:0], b};
			end else if (byte_count_q < 17'd8) begin
				if (b != cookie_b) n_fail = 1'b1;
			end else if (check_tid_q && b != tid_b) begin
				n_fail = 1'b1;
			end
		end else if (off < {1'b0, body_length_q}) begin
			if (!walk_stopped_q && off >= attr_offset_q) begin
				if (k == 17'd0 && ({1'b0, attr_offset_q} + 18'd4 > {2'b0, body_length_q})) begin
					n_stopped = 1'b1;
				end else if (k < 17'd2) begin
					n_kind = {attr_kind_q[7:0], b};
				end else begin
					if (k < 17'd4) begin
						n_size = {attr_size_q[7:0], b};
						if (k == 17'd3) begin
							n_window = '0;
							if ({1'b0, attr_offset_q} + 18'd4 + {2'b0, n_size}
									> {2'b0, body_length_q}) begin
								n_stopped = 1'b1;
								stop_now  = 1'b1;
							end
						end
					end else if (v < {1'b0, attr_size_q} && v < 17'd8) begin
						n_window = {value_window_q[55:0], b};
						if (v == 17'd3 && attr_size_q >= 16'd4) begin
							if (attr_kind_q == stun_pkg::AttrLifetime) begin
								n_found.lifetime_seconds = n_window[31:0];
							end else if (attr_kind_q == stun_pkg::AttrError) begin
								n_found.error_valid = 1'b1;
								n_found.error_code  = n_window[15:0];
							end
						end else if (v == 17'd7 && attr_size_q >= 16'd8
								&& n_window[55:48] == stun_pkg::FamilyV4) begin
							port_x = n_window[47:32];
							ip_x   = n_window[31:0];
							// only the plain mapped form skips the cookie mask
							if (attr_kind_q != stun_pkg::AttrMapped) begin
								port_x = port_x ^ stun_pkg::StunCookie[31:16];
								ip_x   = ip_x ^ stun_pkg::StunCookie;
							end
							if (attr_kind_q == stun_pkg::AttrXorRelayed) begin
								n_found.relayed_valid = 1'b1;
								n_found.relayed_ip    = ip_x;
								n_found.relayed_port  = port_x;
							end else if (attr_kind_q == stun_pkg::AttrMapped
									|| attr_kind_q == stun_pkg::AttrXorMapped) begin
								n_found.mapped_valid = 1'b1;
								n_found.mapped_ip    = ip_x;
								n_found.mapped_port  = port_x;
							end
						end
					end
					padded = ({1'b0, n_size} + 17'd3) & ~17'd3;
					// end of padded value: step to the next attribute
					if (!stop_now && k >= 17'd3 && k == 17'd3 + padded) begin
						n_offset = attr_offset_q + 17'd4 + padded;
						n_kind   = '0;
						n_size   = '0;
					end
				end
			end
		end

		if (byte_count_q != stun_pkg::CountMax) n_count = byte_count_q + 17'd1;

		ok = n_count >= stun_pkg::HdrBytes && !n_fail
			&& {1'b0, n_count} >= {1'b0, stun_pkg::HdrBytes} + {2'b0, n_len};
		res                  = '0;
		res.parse_ok         = ok;
		res.message_type     = (n_count >= stun_pkg::HdrBytes) ? n_type : 16'd0;
		if (ok) begin
			res.mapped_valid     = n_found.mapped_valid;
			res.mapped_ip        = n_found.mapped_ip;
			res.mapped_port      = n_found.mapped_port;
			res.relayed_valid    = n_found.relayed_valid;
			res.relayed_ip       = n_found.relayed_ip;
			res.relayed_port     = n_found.relayed_port;
			res.lifetime_seconds = n_found.lifetime_seconds;
			res.error_valid      = n_found.error_valid;
			res.error_code       = n_found.error_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_tid_q <= 1'b0;
			tid_high_q  <= '0;
			tid_low_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stun_pkg::CfgCheckTid: check_tid_q <= cfg_data[0];
				stun_pkg::CfgTidHigh:  tid_high_q  <= cfg_data[31:0];
				stun_pkg::CfgTidLow:   tid_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) data_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_type_q  <= '0;
			body_length_q  <= '0;
			header_fail_q  <= 1'b0;
			walk_stopped_q <= 1'b0;
			attr_kind_q    <= '0;
			attr_size_q    <= '0;
			attr_offset_q  <= '0;
			value_window_q <= '0;
			found_q        <= '0;
		end else if (adv) begin
			if (data_s1.last_byte) begin
				// rearm for the next datagram
				byte_count_q   <= '0;
				header_type_q  <= '0;
				body_length_q  <= '0;
				header_fail_q  <= 1'b0;
				walk_stopped_q <= 1'b0;
				attr_kind_q    <= '0;
				attr_size_q    <= '0;
				attr_offset_q  <= '0;
				value_window_q <= '0;
				found_q        <= '0;
			end else begin
				byte_count_q   <= n_count;
				header_type_q  <= n_type;
				body_length_q  <= n_len;
				header_fail_q  <= n_fail;
				walk_stopped_q <= n_stopped;
				attr_kind_q    <= n_kind;
				attr_size_q    <= n_size;
				attr_offset_q  <= n_offset;
				value_window_q <= n_window;
				found_q        <= n_found;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && data_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && data_s1.last_byte) out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ verif/parse_summary_compare.sv @@
`timescale 1ns / 1ps

module parse_summary_compare
	import stun_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          passed
);

	logic        tid_check;
	logic [31:0] tid_hi;
	logic [63:0] tid_lo;

	logic [16:0] rx_count;
	logic [15:0] hdr_type;
	logic [15:0] body_len;
	logic        hdr_bad;
	logic        walk_done;
	logic [15:0] cur_kind;
	logic [15:0] cur_len;
	int unsigned cur_base;
	logic [63:0] val_win;
	found_t      decoded;

	out_t summaries_due[$];

	task automatic clear_parse();
		rx_count = '0;
		hdr_type = '0;
		body_len = '0;
		hdr_bad = 1'b0;
		walk_done = 1'b0;
		cur_kind = '0;
		cur_len = '0;
		cur_base = 0;
		val_win = '0;
		decoded = '0;
	endtask

	// one message byte through the header checks and the attribute walk
	task automatic take_byte(input logic [7:0] b, input logic fin);
		int unsigned pos, k, v, padded;
		logic [95:0] tid;
		logic        ok;
		out_t        s;
		pos = rx_count;
		tid = {tid_hi, tid_lo};
		if (pos < 2) begin
			hdr_type = {hdr_type[7:0], b};
		end else if (pos < 4) begin
			body_len = {body_len[7:0], b};
		end else if (pos < 8) begin
			if (b != StunCookie[8 * (7 - pos) +: 8])
				hdr_bad = 1'b1;
		end else if (pos < HdrBytes) begin
			if (tid_check && b != tid[8 * (19 - pos) +: 8])
				hdr_bad = 1'b1;
		end else if (pos - HdrBytes < body_len && !walk_done && pos - HdrBytes >= cur_base) begin
			k = pos - HdrBytes - cur_base;
			if (k == 0 && cur_base + 4 > body_len) begin
				walk_done = 1'b1;
			end else if (k < 2) begin
				cur_kind = {cur_kind[7:0], b};
			end else begin
				if (k < 4) begin
					cur_len = {cur_len[7:0], b};
					if (k == 3) begin
						val_win = '0;
						if (cur_base + 4 + cur_len > body_len)
							walk_done = 1'b1;
					end
				end else if (k - 4 < cur_len && k - 4 < 8) begin
					val_win = {val_win[55:0], b};
					v = k - 4;
					if (v == 3 && cur_len >= 4) begin
						if (cur_kind == AttrLifetime) begin
							decoded.lifetime_seconds = val_win[31:0];
						end else if (cur_kind == AttrError) begin
							decoded.error_valid = 1'b1;
							decoded.error_code = val_win[15:0];
						end
					end else if (v == 7 && cur_len >= 8 && val_win[55:48] == FamilyV4) begin
						if (cur_kind == AttrXorRelayed) begin
							decoded.relayed_valid = 1'b1;
							decoded.relayed_ip = val_win[31:0] ^ StunCookie;
							decoded.relayed_port = val_win[47:32] ^ StunCookie[31:16];
						end else if (cur_kind == AttrMapped) begin
							decoded.mapped_valid = 1'b1;
							decoded.mapped_ip = val_win[31:0];
							decoded.mapped_port = val_win[47:32];
						end else if (cur_kind == AttrXorMapped) begin
							decoded.mapped_valid = 1'b1;
							decoded.mapped_ip = val_win[31:0] ^ StunCookie;
							decoded.mapped_port = val_win[47:32] ^ StunCookie[31:16];
						end
					end
				end
				// step to the next attribute once the padded value is consumed
				padded = (int'(cur_len) + 3) & ~32'd3;
				if (!walk_done && k >= 3 && k == 3 + padded) begin
					cur_base = cur_base + 4 + padded;
					cur_kind = '0;
					cur_len = '0;
				end
			end
		end
		if (rx_count != CountMax)
			rx_count = rx_count + 1'b1;
		if (fin) begin
			ok = rx_count >= HdrBytes && !hdr_bad &&
				int'(rx_count) >= int'(HdrBytes) + int'(body_len);
			s = '0;
			s.parse_ok = ok;
			s.message_type = (rx_count >= HdrBytes) ? hdr_type : 16'h0000;
			if (ok) begin
				s.mapped_valid = decoded.mapped_valid;
				s.mapped_ip = decoded.mapped_ip;
				s.mapped_port = decoded.mapped_port;
				s.relayed_valid = decoded.relayed_valid;
				s.relayed_ip = decoded.relayed_ip;
				s.relayed_port = decoded.relayed_port;
				s.lifetime_seconds = decoded.lifetime_seconds;
				s.error_valid = decoded.error_valid;
				s.error_code = decoded.error_code;
			end
			summaries_due.push_back(s);
			clear_parse();
		end
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			tid_check = 1'b0;
			tid_hi = '0;
			tid_lo = '0;
			clear_parse();
			summaries_due.delete();
			errors = 0;
			checked = 0;
			passed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgCheckTid: tid_check = cfg_data[0];
					CfgTidHigh:  tid_hi = cfg_data[31:0];
					CfgTidLow:   tid_lo = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (summaries_due.size() == 0) begin
					$error("summary transaction with none expected");
					errors++;
				end else begin
					want = summaries_due.pop_front();
					checked++;
					if (want.parse_ok)
						passed++;
					cmp_field("parse_ok", want.parse_ok, out_data.parse_ok);
					cmp_field("message_type", want.message_type, out_data.message_type);
					cmp_field("mapped_valid", want.mapped_valid, out_data.mapped_valid);
					cmp_field("mapped_ip", want.mapped_ip, out_data.mapped_ip);
					cmp_field("mapped_port", want.mapped_port, out_data.mapped_port);
					cmp_field("relayed_valid", want.relayed_valid, out_data.relayed_valid);
					cmp_field("relayed_ip", want.relayed_ip, out_data.relayed_ip);
					cmp_field("relayed_port", want.relayed_port, out_data.relayed_port);
					cmp_field("lifetime_seconds", want.lifetime_seconds,
						out_data.lifetime_seconds);
					cmp_field("error_valid", want.error_valid, out_data.error_valid);
					cmp_field("error_code", want.error_code, out_data.error_code);
				end
			end
			if (in_valid && !in_stall)
				take_byte(in_data.data_byte, in_data.last_byte);
		end
		pending = summaries_due.size();
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import stun_pkg::*;

	localparam int IdleLimit = 2000;

	localparam logic [15:0] BindSuccess    = 16'h0101;
	localparam logic [15:0] BindError      = 16'h0111;
	localparam logic [15:0] AllocSuccess   = 16'h0103;
	localparam logic [15:0] AllocError     = 16'h0113;
	localparam logic [15:0] RefreshSuccess = 16'h0104;

	typedef enum {
		MsgGood, MsgTrailing, MsgLenOverrun, MsgBadCookie, MsgBadTid,
		MsgTruncated, MsgShort, MsgNoise
	} msg_shape_e;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CfgCheckTid;
	logic [63:0] cfg_data = '0;

	int errors, pending, checked, passed;

	logic [7:0]  msg[$];
	logic [7:0]  body[$];
	bit          calm;
	int          bytes_sent, datagrams, idle_cycles;
	logic        tid_check_on;
	logic [31:0] tid_hi;
	logic [63:0] tid_lo;

	stun_response_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	parse_summary_compare u_summary_compare (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.passed    (passed)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// no transaction on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IdleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stalls: mostly short bursts, some long, some long open stretches
	initial begin
		int r, len;
		logic v;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				v = 1'b0;
				len = $urandom_range(1, 6);
			end else if (r < 80) begin
				v = 1'b1;
				len = $urandom_range(1, 3);
			end else if (r < 92) begin
				v = 1'b1;
				len = $urandom_range(8, 40);
			end else begin
				v = 1'b0;
				len = $urandom_range(30, 80);
			end
			@(negedge clk);
			out_stall <= v;
			repeat (len - 1) @(negedge clk);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		int  r, gap;
		in_t item;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(5, 30);
		item.data_byte = b;
		item.last_byte = fin;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_msg();
		calm = ($urandom_range(0, 3) == 0);
		foreach (msg[i])
			push_byte(msg[i], i == msg.size() - 1);
		datagrams++;
	endtask

	// appends one attribute (header, value, padding) to the body; sel picks the kind
	task automatic random_attr(input int sel);
		logic [15:0] kind;
		logic [7:0]  b;
		int          len, r;
		case (sel)
			0: kind = AttrMapped;
			1: kind = AttrXorMapped;
			2: kind = AttrXorRelayed;
			3: kind = AttrLifetime;
			4: kind = AttrError;
			default: kind = 16'($urandom);
		endcase
		r = $urandom_range(0, 9);
		if (sel < 3)
			len = (r < 7) ? 8 : (r < 9) ? $urandom_range(9, 20) : $urandom_range(0, 7);
		else if (sel < 5)
			len = (r < 7) ? 4 : (r < 9) ? $urandom_range(5, 24) : $urandom_range(0, 3);
		else
			len = $urandom_range(0, 24);
		body.push_back(kind[15:8]);
		body.push_back(kind[7:0]);
		body.push_back(8'(len >> 8));
		body.push_back(8'(len));
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (sel < 3 && i == 1 && $urandom_range(0, 7) != 0)
				b = FamilyV4;
			body.push_back(b);
		end
		repeat ((4 - len % 4) % 4) body.push_back(8'($urandom));
	endtask

	task automatic build_msg(input msg_shape_e shape, input int n_attr, input bit every_kind);
		logic [15:0] mtype, blen;
		logic [95:0] tid;
		bit          rnd_tid;
		int          r, cut;
		body.delete();
		msg.delete();
		if (every_kind)
			for (int s = 0; s < 6; s++)
				random_attr(s);
		repeat (n_attr) random_attr($urandom_range(0, 5));
		blen = 16'(body.size());
		if (shape == MsgLenOverrun && body.size() > 0)
			blen = 16'($urandom_range(0, body.size() - 1));
		r = $urandom_range(0, 5);
		case (r)
			0: mtype = BindSuccess;
			1: mtype = BindError;
			2: mtype = AllocSuccess;
			3: mtype = AllocError;
			4: mtype = RefreshSuccess;
			default: mtype = 16'($urandom);
		endcase
		msg.push_back(mtype[15:8]);
		msg.push_back(mtype[7:0]);
		msg.push_back(blen[15:8]);
		msg.push_back(blen[7:0]);
		for (int i = 0; i < 4; i++)
			msg.push_back(StunCookie[31 - 8 * i -: 8]);
		tid = {tid_hi, tid_lo};
		rnd_tid = !tid_check_on && $urandom_range(0, 1);
		for (int i = 0; i < 12; i++)
			msg.push_back(rnd_tid ? 8'($urandom) : tid[95 - 8 * i -: 8]);
		if (shape == MsgBadCookie)
			msg[$urandom_range(4, 7)] ^= 8'(1 << $urandom_range(0, 7));
		if (shape == MsgBadTid)
			msg[$urandom_range(8, 19)] ^= 8'(1 << $urandom_range(0, 7));
		foreach (body[i])
			msg.push_back(body[i]);
		case (shape)
			MsgTruncated: begin
				cut = $urandom_range(1, (body.size() > 0) ? body.size() : 1);
				repeat (cut) void'(msg.pop_back());
			end
			MsgShort: begin
				cut = $urandom_range(1, 19);
				while (msg.size() > cut)
					void'(msg.pop_back());
			end
			MsgTrailing: repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
			MsgNoise: begin
				msg.delete();
				repeat ($urandom_range(1, 48)) msg.push_back(8'($urandom));
			end
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic chk, input logic [31:0] hi, input logic [63:0] lo);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(posedge clk);
		write_reg(CfgCheckTid, 64'(chk));
		write_reg(CfgTidHigh, 64'(hi));
		write_reg(CfgTidLow, lo);
		tid_check_on = chk;
		tid_hi = hi;
		tid_lo = lo;
	endtask

	task automatic run_random(input int target);
		int         start, n0, r;
		msg_shape_e shape;
		start = bytes_sent;
		n0 = datagrams;
		while (bytes_sent - start < target || datagrams - n0 < 4) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				shape = MsgGood;
			else if (r < 65)
				shape = MsgTrailing;
			else if (r < 75)
				shape = MsgLenOverrun;
			else if (r < 80)
				shape = MsgBadCookie;
			else if (r < 85)
				shape = MsgBadTid;
			else if (r < 90)
				shape = MsgTruncated;
			else if (r < 95)
				shape = MsgShort;
			else
				shape = MsgNoise;
			build_msg(shape, $urandom_range(0, 4), 1'b0);
			send_msg();
		end
	endtask

	initial begin
		tid_check_on = 1'b0;
		tid_hi = '0;
		tid_lo = '0;
		calm = 1'b0;
		bytes_sent = 0;
		datagrams = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed datagrams with the reset configuration
		build_msg(MsgGood, 0, 1'b1);
		send_msg();
		build_msg(MsgGood, 0, 1'b0);
		msg[0] = 8'h00;
		msg[1] = 8'h00;
		send_msg();
		build_msg(MsgGood, 3, 1'b0);
		msg[0] = 8'hFF;
		msg[1] = 8'hFF;
		send_msg();
		build_msg(MsgTrailing, 1, 1'b1);
		send_msg();
		build_msg(MsgLenOverrun, 4, 1'b0);
		send_msg();
		build_msg(MsgBadCookie, 2, 1'b0);
		send_msg();
		build_msg(MsgTruncated, 2, 1'b0);
		send_msg();
		build_msg(MsgShort, 0, 1'b0);
		send_msg();
		build_msg(MsgNoise, 0, 1'b0);
		send_msg();
		msg.delete();
		msg.push_back(8'hFF);
		send_msg();
		msg.delete();
		repeat (24) msg.push_back(8'h00);
		send_msg();
		run_random(240);

		set_config(1'b1, $urandom, {$urandom, $urandom});
		build_msg(MsgBadTid, 2, 1'b0);
		send_msg();
		build_msg(MsgGood, 0, 1'b1);
		send_msg();
		run_random(240);

		set_config(1'b1, '1, '1);
		run_random(240);

		set_config(1'b1, '0, '0);
		run_random(240);

		// ID compare off: a mismatching ID must still parse
		set_config(1'b0, $urandom, {$urandom, $urandom});
		build_msg(MsgBadTid, 2, 1'b0);
		send_msg();
		run_random(240);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(posedge clk);

		$display("covered %0d datagrams in %0d bytes under 5 register settings",
			datagrams, bytes_sent);
		$display("compared %0d summaries, %0d of them clean parses", checked, passed);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
